// File: hdl/iss_pkg.sv
// shared types and constants for the integer set store
package iss_pkg;

  // field widths fixed by the interface
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CAP_W   = 8;
  localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // input beat
  typedef struct packed {
    logic                      op;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  // result beat
  typedef struct packed {
    logic               was_present;
    logic               changed;
    logic               overflow;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan_step;
    logic append;
    logic flag_ovf;
    logic shift_init;
    logic shift_step;
    logic dec_count;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic count_zero;
    logic hit;
    logic miss;
    logic found;
    logic op_remove;
    logic room;
    logic stream_idle;
  } sts_t;

  // controller states, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_REPLY  = 5'b10000
  } state_t;

endpackage

// File: hdl/iss_ctrl.sv
// controller state machine for the integer set store
module iss_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  iss_pkg::sts_t sts,
  output iss_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);

  iss_pkg::state_t state;
  iss_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      iss_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = sts.count_zero ? iss_pkg::S_DECIDE : iss_pkg::S_SCAN;
        end
      end
      iss_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit || sts.miss) begin
          state_next = iss_pkg::S_DECIDE;
        end
      end
      iss_pkg::S_DECIDE: begin
        if (!sts.op_remove) begin
          if (!sts.found) begin
            if (sts.room) begin
              cmd.append = 1'b1;
            end else begin
              cmd.flag_ovf = 1'b1;
            end
          end
          state_next = iss_pkg::S_REPLY;
        end else if (sts.found) begin
          cmd.shift_init = 1'b1;
          state_next     = iss_pkg::S_SHIFT;
        end else begin
          state_next = iss_pkg::S_REPLY;
        end
      end
      iss_pkg::S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.stream_idle) begin
          cmd.dec_count = 1'b1;
          state_next    = iss_pkg::S_REPLY;
        end
      end
      iss_pkg::S_REPLY: begin
        state_next = iss_pkg::S_IDLE;
      end
      default: begin
        state_next = iss_pkg::S_IDLE;
      end
    endcase
  end

  // handshake flags
  assign busy = (state != iss_pkg::S_IDLE);
  assign done = (state == iss_pkg::S_REPLY);

endmodule

// File: hdl/iss_datapath.sv
// datapath of the integer set store: entry memory, counters and compare
module iss_datapath #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  iss_pkg::req_t                 req,
  input  logic                          cfg_we,
  input  logic [iss_pkg::CAP_W-1:0]     cfg_wdata,
  input  iss_pkg::cmd_t                 cmd,
  output iss_pkg::sts_t                 sts,
  output iss_pkg::rsp_t                 rsp
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > iss_pkg::CAP_W) ? CW : iss_pkg::CAP_W;

  logic [iss_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [iss_pkg::VALUE_W-1:0] rdata;
  logic [iss_pkg::VALUE_W-1:0] value_q;
  logic                        op_q;
  logic [iss_pkg::CAP_W-1:0]   capacity;
  logic [CW-1:0]               count;
  logic [CW-1:0]               ridx;
  logic [AW-1:0]               cidx;
  logic [AW-1:0]               pos;
  logic                        vld;
  logic                        found_q;
  logic                        changed_q;
  logic                        overflow_q;

  logic                        step;
  logic                        issue;
  logic                        match;
  logic [LW-1:0]               count_ext;
  logic [LW-1:0]               cap_ext;
  logic [LW-1:0]               limit;
  logic                        mem_we;
  logic [AW-1:0]               waddr;
  logic [iss_pkg::VALUE_W-1:0] wdata;

  // stream of reads over held entries, one per cycle while the controller scans or shifts
  assign step      = cmd.scan_step | cmd.shift_step;
  assign issue     = (ridx < count);
  assign match     = vld && (rdata == value_q);

  // usable limit is the smaller of capacity and depth
  assign count_ext = LW'(count);
  assign cap_ext   = LW'(capacity);
  assign limit     = (cap_ext < LW'(DEPTH)) ? cap_ext : LW'(DEPTH);

  // single write port: append at the end or move an entry down
  assign mem_we = cmd.append | (cmd.shift_step & vld);
  assign waddr  = cmd.append ? count[AW-1:0] : (cidx - AW'(1));
  assign wdata  = cmd.append ? value_q : rdata;

  // entry memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (step && issue) begin
      rdata <= mem[ridx[AW-1:0]];
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= iss_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_q <= req.value;
      op_q    <= req.op;
    end
  end

  // match position
  always_ff @(posedge clk) begin
    if (cmd.scan_step && match) begin
      pos <= cidx;
    end
  end

  // read stream control
  always_ff @(posedge clk) begin
    if (rst) begin
      ridx <= '0;
      vld  <= 1'b0;
      cidx <= '0;
    end else if (cmd.load) begin
      ridx <= '0;
      vld  <= 1'b0;
    end else if (cmd.shift_init) begin
      ridx <= CW'(pos) + CW'(1);
      vld  <= 1'b0;
    end else if (step) begin
      ridx <= ridx + CW'(issue);
      vld  <= issue;
      cidx <= ridx[AW-1:0];
    end
  end

  // entry count and result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      found_q    <= 1'b0;
      changed_q  <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      if (cmd.load) begin
        found_q    <= 1'b0;
        changed_q  <= 1'b0;
        overflow_q <= 1'b0;
      end
      if (cmd.scan_step && match) begin
        found_q <= 1'b1;
      end
      if (cmd.append) begin
        count     <= count + CW'(1);
        changed_q <= 1'b1;
      end
      if (cmd.dec_count) begin
        count     <= count - CW'(1);
        changed_q <= 1'b1;
      end
      if (cmd.flag_ovf) begin
        overflow_q <= 1'b1;
      end
    end
  end

  // status to the controller
  assign sts.count_zero  = (count == '0);
  assign sts.hit         = match;
  assign sts.miss        = vld && !match && ((CW'(cidx) + CW'(1)) == count);
  assign sts.found       = found_q;
  assign sts.op_remove   = (op_q == iss_pkg::OP_REMOVE);
  assign sts.room        = (count_ext < limit);
  assign sts.stream_idle = !issue && !vld;

  // result beat
  assign rsp.was_present = found_q;
  assign rsp.changed     = changed_q;
  assign rsp.overflow    = overflow_q;
  assign rsp.count       = count_ext[iss_pkg::COUNT_W-1:0];

  // count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  // an append grows the count by exactly one
  a_append_inc: assert property (@(posedge clk) disable iff (rst)
    cmd.append |=> count == $past(count) + CW'(1))
    else $error("append did not grow count");

  // a moved entry lands inside the held range
  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_step && vld) |-> (CW'(cidx) < count) && (cidx != '0))
    else $error("shift write outside held entries");

  // an overflow is only raised on an insert of an absent value
  a_ovf_insert: assert property (@(posedge clk) disable iff (rst)
    cmd.flag_ovf |-> !found_q && (op_q == iss_pkg::OP_INSERT) && !sts.room)
    else $error("overflow on a wrong case");

endmodule

// File: hdl/integer_set_store_core.sv
// top level of the integer set store: controller plus datapath
//
//  channel   signals                      handshake
//  input     start, busy, req             taken when start high and busy low
//  result    done, rsp                    one beat, valid for the one cycle done is high
//  config    cfg_we, cfg_wdata            capacity written when cfg_we high
//
// an absent value is compared against every held entry (no scan on an empty store), an
// insert that hits stops the scan at the hit, and a remove that hits shifts later
// entries down; the entry memory gives one read per cycle, which sets both the scan
// and the shift.
// reset is synchronous, clears count and sets capacity to 100; entries are not cleared.
// results cannot be held off: done is a one-cycle strobe, busy stays high until it.
module integer_set_store_core #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  iss_pkg::req_t             req,
  output logic                      done,
  output iss_pkg::rsp_t             rsp,
  input  logic                      cfg_we,
  input  logic [iss_pkg::CAP_W-1:0] cfg_wdata
);

  iss_pkg::cmd_t cmd;
  iss_pkg::sts_t sts;

  // sequencing
  iss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // storage and compare
  iss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule
